>>> rtl/chained_hash_table_core_defines.svh
// Assertion macros used by the chained hash table RTL.
`ifndef CHAINED_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CHT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cht_pkg.sv
// Shared constants, codes and helpers for the chained hash table.
`default_nettype none

package cht_pkg;

  localparam int MAX_BUCKETS = 128;
  localparam int NODE_COUNT  = 256;

  localparam int VALUE_W = 31;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 8;
  localparam int BKT_W   = $clog2(MAX_BUCKETS);
  localparam int CNT_W   = BKT_W + 1;
  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int LINK_W  = NODE_W + 1;

  // Modulo unit: bits of the dividend retired per cycle, and steps per item.
  localparam int MOD_DIGIT_W = 4;
  localparam int MOD_STEPS   = (VALUE_W + MOD_DIGIT_W - 1) / MOD_DIGIT_W;

  localparam logic [LINK_W-1:0] LINK_NONE  = LINK_W'(NODE_COUNT);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = CNT_W'(MAX_BUCKETS);
  localparam logic [CNT_W-1:0]  COUNT_RST  = CNT_W'(100);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  function automatic logic link_ok(input logic [LINK_W-1:0] l);
    return l < LINK_W'(NODE_COUNT);
  endfunction

endpackage

`default_nettype wire

>>> rtl/cht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/cht_mod.sv
// Iterative modulo unit: value mod bucket count, several dividend bits per cycle.
`default_nettype none

module cht_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cht_pkg::VALUE_W-1:0] dividend,
  input  logic [cht_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [cht_pkg::BKT_W-1:0]   rem
);

  localparam int DIG   = cht_pkg::MOD_DIGIT_W;
  localparam int STEPS = cht_pkg::MOD_STEPS;
  localparam int SH_W  = STEPS * DIG;
  localparam int STP_W = $clog2(STEPS);
  localparam int PAD_W = SH_W - cht_pkg::VALUE_W;

  logic                            busy;
  logic [STP_W-1:0]                step;
  logic [SH_W-1:0]                 shift;
  logic [cht_pkg::BKT_W-1:0]       r_work;
  logic [cht_pkg::CNT_W-1:0]       trial;

  // Restoring remainder over one digit; the partial remainder stays below the divisor.
  always_comb begin
    r_work = rem;
    trial  = '0;
    for (int i = 0; i < DIG; i++) begin
      trial = {r_work, shift[SH_W-1-i]};
      if (trial >= divisor) begin
        trial = trial - divisor;
      end
      r_work = trial[cht_pkg::BKT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STP_W'(1);
        if (step == STP_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= {{PAD_W{1'b0}}, dividend};
      rem   <= '0;
    end else if (busy) begin
      shift <= shift << DIG;
      rem   <= r_work;
    end
  end

endmodule

`default_nettype wire

>>> rtl/chained_hash_table_core.sv
// Top level of the chained hash table: sequencer, bucket heads and node pool.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------
//   in      | input     | in_valid / in_ready   | command, value
//   out     | output    | out_valid / out_ready | found, bucket, status
//   cfg     | input     | cfg_write             | cfg_data (bucket count)
//
// One item at a time: the transfer, the modulo (8 steps of 4 value bits in the remainder
// unit, then its done strobe), a bucket head read, a free list read when a recycled node
// is taken, then one node RAM read per chain node visited, an unlink step for a delete,
// and a load of the result register.
// Reset is synchronous; all buckets read empty through per-bucket valid bits, no sweep.
// A result waiting on out_ready holds in the output register while the next item runs;
// that next item then stalls in its load state until the register frees up.
`default_nettype none

`include "chained_hash_table_core_defines.svh"

module chained_hash_table_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cht_pkg::CMD_W-1:0]   command,
  input  logic [cht_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [cht_pkg::BKT_W-1:0]   bucket,
  output logic [1:0]                  status,
  input  logic                        cfg_write,
  input  logic [cht_pkg::CFG_W-1:0]   cfg_data
);

  localparam int NODE_W = cht_pkg::NODE_W;
  localparam int LINK_W = cht_pkg::LINK_W;
  localparam int BKT_W  = cht_pkg::BKT_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MOD    = 7'b0000010,
    S_HEAD   = 7'b0000100,
    S_ALLOC  = 7'b0001000,
    S_WALK   = 7'b0010000,
    S_UNLINK = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Configuration: effective bucket count, clamped to 1..MAX_BUCKETS.
  logic [cht_pkg::CNT_W-1:0] bucket_count;

  // Item in flight.
  logic [cht_pkg::CMD_W-1:0]   cmd;
  logic [cht_pkg::VALUE_W-1:0] val;

  // Chain walk and pool bookkeeping.
  logic [LINK_W-1:0] p, p_next;
  logic [LINK_W-1:0] prev, prev_next;
  logic [NODE_W-1:0] newn, newn_next;
  logic [LINK_W-1:0] free_head, free_head_next;
  logic [LINK_W-1:0] fresh, fresh_next;
  logic [cht_pkg::MAX_BUCKETS-1:0] head_valid;

  logic             res_found, res_found_next;
  cht_pkg::status_t res_status, res_status_next;
  logic             res_found_q;
  logic             out_load;
  cht_pkg::status_t out_status;

  // Modulo unit.
  logic             mod_start;
  logic             mod_done;
  logic [BKT_W-1:0] mod_rem;

  // Memory ports.
  logic                       heads_we;
  logic [LINK_W-1:0]          heads_wdata;
  logic [LINK_W-1:0]          heads_rd;
  logic [NODE_W-1:0]          node_raddr;
  logic                       vals_we;
  logic [cht_pkg::VALUE_W-1:0] vals_rd;
  logic                       links_we;
  logic [NODE_W-1:0]          links_waddr;
  logic [LINK_W-1:0]          links_wdata;
  logic [LINK_W-1:0]          links_rd;

  // Allocation of a node for an insert, shared by the fresh and recycled paths.
  logic              alloc_go;
  logic [NODE_W-1:0] alloc_node;
  logic [LINK_W-1:0] head_cur;
  logic [LINK_W-1:0] p_cur;

  assign in_ready = (state == S_IDLE);
  assign found    = res_found_q;
  assign status   = out_status;

  cht_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (value),
    .divisor  (bucket_count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Bucket heads: read at the bucket the modulo unit holds, written at the same bucket.
  cht_ram #(.WIDTH(LINK_W), .DEPTH(cht_pkg::MAX_BUCKETS)) u_heads (
    .clk   (clk),
    .we    (heads_we),
    .waddr (mod_rem),
    .wdata (heads_wdata),
    .raddr (mod_rem),
    .rdata (heads_rd)
  );

  cht_ram #(.WIDTH(cht_pkg::VALUE_W), .DEPTH(cht_pkg::NODE_COUNT)) u_vals (
    .clk   (clk),
    .we    (vals_we),
    .waddr (alloc_node),
    .wdata (val),
    .raddr (node_raddr),
    .rdata (vals_rd)
  );

  cht_ram #(.WIDTH(LINK_W), .DEPTH(cht_pkg::NODE_COUNT)) u_links (
    .clk   (clk),
    .we    (links_we),
    .waddr (links_waddr),
    .wdata (links_wdata),
    .raddr (node_raddr),
    .rdata (links_rd)
  );

  // A bucket never written since reset reads as an empty chain.
  assign head_cur = head_valid[mod_rem] ? heads_rd : cht_pkg::LINK_NONE;
  assign p_cur    = (state == S_HEAD) ? head_cur : p;

  always_comb begin
    state_next      = state;
    p_next          = p;
    prev_next       = prev;
    newn_next       = newn;
    free_head_next  = free_head;
    fresh_next      = fresh;
    res_found_next  = res_found;
    res_status_next = res_status;
    mod_start       = 1'b0;
    node_raddr      = p[NODE_W-1:0];
    vals_we         = 1'b0;
    links_we        = 1'b0;
    links_waddr     = p[NODE_W-1:0];
    links_wdata     = cht_pkg::LINK_NONE;
    heads_we        = 1'b0;
    heads_wdata     = cht_pkg::LINK_NONE;
    alloc_go        = 1'b0;
    alloc_node      = fresh[NODE_W-1:0];
    out_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          mod_start  = 1'b1;
          state_next = S_MOD;
        end
      end

      S_MOD: begin
        if (mod_done) begin
          state_next = S_HEAD;
        end
      end

      S_HEAD: begin
        p_next    = head_cur;
        prev_next = cht_pkg::LINK_NONE;
        unique case (cmd)
          cht_pkg::CMD_INSERT: begin
            if (cht_pkg::link_ok(free_head)) begin
              // Fetch the next free node before reusing the head of the free list.
              node_raddr = free_head[NODE_W-1:0];
              state_next = S_ALLOC;
            end else if (fresh < LINK_W'(cht_pkg::NODE_COUNT)) begin
              alloc_go   = 1'b1;
              alloc_node = fresh[NODE_W-1:0];
              fresh_next = fresh + LINK_W'(1);
            end else begin
              res_found_next  = 1'b0;
              res_status_next = cht_pkg::ST_FULL;
              state_next      = S_DONE;
            end
          end
          cht_pkg::CMD_SEARCH, cht_pkg::CMD_DELETE: begin
            if (cht_pkg::link_ok(head_cur)) begin
              node_raddr = head_cur[NODE_W-1:0];
              state_next = S_WALK;
            end else begin
              res_found_next  = 1'b0;
              res_status_next = cht_pkg::ST_NOT_FOUND;
              state_next      = S_DONE;
            end
          end
          default: begin
            res_found_next  = 1'b0;
            res_status_next = cht_pkg::ST_NOT_FOUND;
            state_next      = S_DONE;
          end
        endcase
      end

      S_ALLOC: begin
        alloc_go       = 1'b1;
        alloc_node     = free_head[NODE_W-1:0];
        free_head_next = links_rd;
      end

      S_WALK: begin
        unique case (cmd)
          cht_pkg::CMD_INSERT: begin
            if (cht_pkg::link_ok(links_rd)) begin
              p_next     = links_rd;
              node_raddr = links_rd[NODE_W-1:0];
            end else begin
              // Tail reached: hook the new node on.
              links_we        = 1'b1;
              links_waddr     = p[NODE_W-1:0];
              links_wdata     = {1'b0, newn};
              res_found_next  = 1'b1;
              res_status_next = cht_pkg::ST_OK;
              state_next      = S_DONE;
            end
          end
          cht_pkg::CMD_SEARCH: begin
            if (vals_rd == val) begin
              res_found_next  = 1'b1;
              res_status_next = cht_pkg::ST_OK;
              state_next      = S_DONE;
            end else if (cht_pkg::link_ok(links_rd)) begin
              p_next     = links_rd;
              node_raddr = links_rd[NODE_W-1:0];
            end else begin
              res_found_next  = 1'b0;
              res_status_next = cht_pkg::ST_NOT_FOUND;
              state_next      = S_DONE;
            end
          end
          cht_pkg::CMD_DELETE: begin
            if (vals_rd == val) begin
              // Bypass the match from its predecessor, or from the bucket head.
              if (cht_pkg::link_ok(prev)) begin
                links_we    = 1'b1;
                links_waddr = prev[NODE_W-1:0];
                links_wdata = links_rd;
              end else begin
                heads_we    = 1'b1;
                heads_wdata = links_rd;
              end
              state_next = S_UNLINK;
            end else if (cht_pkg::link_ok(links_rd)) begin
              prev_next  = p;
              p_next     = links_rd;
              node_raddr = links_rd[NODE_W-1:0];
            end else begin
              res_found_next  = 1'b0;
              res_status_next = cht_pkg::ST_NOT_FOUND;
              state_next      = S_DONE;
            end
          end
          default: begin
            res_found_next  = 1'b0;
            res_status_next = cht_pkg::ST_NOT_FOUND;
            state_next      = S_DONE;
          end
        endcase
      end

      S_UNLINK: begin
        // Push the freed node onto the free list.
        links_we        = 1'b1;
        links_waddr     = p[NODE_W-1:0];
        links_wdata     = free_head;
        free_head_next  = p;
        res_found_next  = 1'b1;
        res_status_next = cht_pkg::ST_OK;
        state_next      = S_DONE;
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Store the new node, then either start the chain or walk to its tail.
    if (alloc_go) begin
      vals_we     = 1'b1;
      links_we    = 1'b1;
      links_waddr = alloc_node;
      links_wdata = cht_pkg::LINK_NONE;
      newn_next   = alloc_node;
      if (cht_pkg::link_ok(p_cur)) begin
        node_raddr = p_cur[NODE_W-1:0];
        state_next = S_WALK;
      end else begin
        heads_we        = 1'b1;
        heads_wdata     = {1'b0, alloc_node};
        res_found_next  = 1'b1;
        res_status_next = cht_pkg::ST_OK;
        state_next      = S_DONE;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      bucket_count <= cht_pkg::COUNT_RST;
      free_head    <= cht_pkg::LINK_NONE;
      fresh        <= '0;
      head_valid   <= '0;
      out_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      if (heads_we) begin
        head_valid[mod_rem] <= 1'b1;
      end
      if (cfg_write) begin
        // Clamp: zero acts as one, anything past the table size saturates.
        if (cfg_data == '0) begin
          bucket_count <= cht_pkg::CNT_W'(1);
        end else if (cht_pkg::CNT_W'(cfg_data) > cht_pkg::COUNT_MAX) begin
          bucket_count <= cht_pkg::COUNT_MAX;
        end else begin
          bucket_count <= cht_pkg::CNT_W'(cfg_data);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= command;
      val <= value;
    end
    p          <= p_next;
    prev       <= prev_next;
    newn       <= newn_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
    if (out_load) begin
      res_found_q <= res_found;
      bucket      <= mod_rem;
      out_status  <= res_status;
    end
  end

  // A reported hit and an ok status always travel together.
  `CHT_ASSERT_NOW(a_found_ok, out_valid,
                  found == (out_status == cht_pkg::ST_OK), "found and status disagree")
  // The free list head is a pool node or the empty link, never anything else.
  `CHT_ASSERT_NOW(a_free_head, !cht_pkg::link_ok(free_head),
                  free_head == cht_pkg::LINK_NONE, "free list head out of range")
  // The modulo unit only finishes while the sequencer waits for it.
  `CHT_ASSERT_NOW(a_mod_sync, mod_done, state == S_MOD,
                  "modulo result outside its wait state")

endmodule

`default_nettype wire
